>>> src/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  localparam int MAX_SLOTS_DEF = 4;
  localparam logic [2:0] TASK_COUNT_RST = 3'd3;
  localparam logic [31:0] SLEEP_LIMIT = 32'h7FFF_FFFF;

  localparam logic [2:0] FN_SCHED = 3'd0;
  localparam logic [2:0] FN_EXIT  = 3'd1;
  localparam logic [2:0] FN_SLEEP = 3'd2;
  localparam logic [2:0] FN_WAKE  = 3'd3;
  localparam logic [2:0] FN_KILL  = 3'd4;
  localparam logic [2:0] FN_READY = 3'd5;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_TOOLONG = 2'd2;
  localparam logic [1:0] STAT_HALT    = 2'd3;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } task_st_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_EVENT,
    OP_PREP,
    OP_MOD,
    OP_SCAN,
    OP_FIX,
    OP_WK_ADDR,
    OP_WK_CMP,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic halted;
    logic is_wake;
    logic ev_sched;
    logic n_zero;
    logic mod_done;
    logic scan_end;
    logic wk_last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> src/rrts_ctrl.sv
// Sequencing state machine of the round-robin task scheduler.
// Issues datapath commands and owns the transfer handshakes; uses rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire rrts_pkg::dp_stat_t stat,
  output rrts_pkg::dp_cmd_t      cmd
);
  import rrts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVENT,
    S_PREP,
    S_MOD,
    S_SCAN,
    S_FIX,
    S_WK_ADDR,
    S_WK_CMP,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    unique case (state_r)
      S_IDLE:    cmd.op = OP_NONE;
      S_EVENT:   cmd.op = OP_EVENT;
      S_PREP:    cmd.op = OP_PREP;
      S_MOD:     cmd.op = OP_MOD;
      S_SCAN:    cmd.op = OP_SCAN;
      S_FIX:     cmd.op = OP_FIX;
      S_WK_ADDR: cmd.op = OP_WK_ADDR;
      S_WK_CMP:  cmd.op = OP_WK_CMP;
      S_DONE:    cmd.op = out_free ? OP_LOAD_OUT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EVENT;
          end
        end
        S_EVENT: begin
          if (stat.halted) begin
            state_r <= S_DONE;
          end else if (stat.is_wake) begin
            state_r <= stat.n_zero ? S_DONE : S_WK_ADDR;
          end else if (stat.ev_sched) begin
            state_r <= S_PREP;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_PREP: begin
          state_r <= stat.n_zero ? S_FIX : S_MOD;
        end
        S_MOD: begin
          if (stat.mod_done) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_end) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          state_r <= S_DONE;
        end
        S_WK_ADDR: begin
          state_r <= S_WK_CMP;
        end
        S_WK_CMP: begin
          state_r <= stat.wk_last ? S_DONE : S_WK_ADDR;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/rrts_dp.sv
// Datapath of the round-robin task scheduler: task table, wakeup memory,
// search registers and result register. Driven by rrts_ctrl; uses rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_dp #(
  parameter int MAX_SLOTS = rrts_pkg::MAX_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rrts_pkg::dp_cmd_t  cmd,
  output rrts_pkg::dp_stat_t      stat,
  input  wire logic [2:0]         in_func,
  input  wire logic [1:0]         in_task_index,
  input  wire logic [31:0]        in_sleep_ms,
  input  wire logic [63:0]        in_tick_now,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_wdata,
  output logic                    out_switched,
  output logic [1:0]              out_prev_task,
  output logic [1:0]              out_next_task,
  output logic [1:0]              out_status
);
  import rrts_pkg::*;

  localparam int SlotW = $clog2(MAX_SLOTS);
  localparam int CntW  = $clog2(MAX_SLOTS + 1);
  localparam int NW    = (CntW > 3) ? CntW : 3;

  task_st_t             ts_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] ctx_r;
  logic [SlotW-1:0]     running_r;
  logic                 halted_r;
  logic [2:0]           tc_r;
  logic [1:0]           status_r;
  logic                 found_r;
  logic [SlotW-1:0]     pick_r;
  logic [CntW-1:0]      rem_r;
  logic [SlotW-1:0]     scan_r;
  logic [CntW-1:0]      cnt_r;
  logic [SlotW-1:0]     wk_idx_r;
  logic [63:0]          wk_q_r;
  logic [63:0]          wk_mem [MAX_SLOTS];

  logic [2:0]           func_r;
  logic [1:0]           idx_r;
  logic [31:0]          ms_r;
  logic [63:0]          now_r;
  logic [SlotW-1:0]     prev_r;

  logic [NW-1:0]        n_ext;
  logic [CntW-1:0]      n;
  logic [SlotW-1:0]     rd_addr;
  task_st_t             rd_st;
  logic                 exit_ok;
  logic                 sleep_ok;
  logic                 kill_ok;
  logic                 ready_ok;
  logic [SlotW-1:0]     idx_slot;
  logic [SlotW-1:0]     scan_next;
  logic                 fallback;
  logic                 commit;
  logic [SlotW-1:0]     pk;

  assign n_ext = (NW'(tc_r) > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(tc_r);
  assign n     = CntW'(n_ext);

  always_comb begin
    case (cmd.op)
      OP_SCAN:   rd_addr = scan_r;
      OP_WK_CMP: rd_addr = wk_idx_r;
      default:   rd_addr = prev_r;
    endcase
  end
  assign rd_st = ts_r[rd_addr];

  assign idx_slot  = SlotW'(idx_r);
  assign exit_ok   = (prev_r != '0);
  assign sleep_ok  = (ms_r != 32'd0) && (ms_r <= SLEEP_LIMIT);
  assign kill_ok   = (prev_r != '0) && (CntW'(prev_r) < n);
  assign ready_ok  = (int'(idx_r) < MAX_SLOTS) && (idx_slot != prev_r);
  assign scan_next = ((CntW'(scan_r) + CntW'(1)) == n) ? '0 : scan_r + SlotW'(1);

  assign fallback = !found_r && (prev_r != '0) && (ts_r[0] != ST_FREE)
                    && (ts_r[0] != ST_SLEEPING);
  assign commit   = found_r || fallback;
  assign pk       = found_r ? pick_r : '0;

  always_comb begin
    stat.halted   = halted_r;
    stat.is_wake  = (func_r == FN_WAKE);
    stat.n_zero   = (n == '0);
    stat.mod_done = (rem_r < n);
    stat.scan_end = (rd_st == ST_READY) || (cnt_r == n - CntW'(1));
    stat.wk_last  = (CntW'(wk_idx_r) == n - CntW'(1));
    case (func_r)
      FN_SCHED: stat.ev_sched = 1'b1;
      FN_EXIT:  stat.ev_sched = exit_ok;
      FN_SLEEP: stat.ev_sched = sleep_ok;
      FN_KILL:  stat.ev_sched = kill_ok;
      default:  stat.ev_sched = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      idx_r  <= in_task_index;
      ms_r   <= in_sleep_ms;
      now_r  <= in_tick_now;
      prev_r <= running_r;
    end
    if (cmd.op == OP_WK_ADDR) begin
      wk_q_r <= wk_mem[wk_idx_r];
    end
    if ((cmd.op == OP_EVENT) && !halted_r && (func_r == FN_SLEEP) && sleep_ok) begin
      wk_mem[prev_r] <= now_r + 64'(ms_r);
    end
    if (cmd.op == OP_LOAD_OUT) begin
      out_switched  <= (running_r != prev_r);
      out_prev_task <= 2'(prev_r);
      out_next_task <= 2'(running_r);
      out_status    <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        ts_r[i] <= ST_FREE;
      end
      ts_r[0]   <= ST_RUNNING;
      ctx_r     <= '0;
      running_r <= '0;
      halted_r  <= 1'b0;
      tc_r      <= TASK_COUNT_RST;
      status_r  <= STAT_DONE;
      found_r   <= 1'b0;
      pick_r    <= '0;
      rem_r     <= '0;
      scan_r    <= '0;
      cnt_r     <= '0;
      wk_idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        tc_r <= cfg_wdata;
      end
      unique case (cmd.op)
        OP_EVENT: begin
          wk_idx_r <= '0;
          if (halted_r) begin
            status_r <= STAT_HALT;
          end else begin
            case (func_r)
              FN_SCHED, FN_WAKE: status_r <= STAT_DONE;
              FN_EXIT: begin
                if (!exit_ok) begin
                  status_r <= STAT_IGNORED;
                end else begin
                  status_r     <= STAT_DONE;
                  ts_r[prev_r] <= ST_FREE;
                  if (ts_r[0] != ST_RUNNING) begin
                    ts_r[0] <= ST_READY;
                  end
                end
              end
              FN_SLEEP: begin
                if (ms_r == 32'd0) begin
                  status_r <= STAT_IGNORED;
                end else if (!sleep_ok) begin
                  status_r <= STAT_TOOLONG;
                end else begin
                  status_r     <= STAT_DONE;
                  ts_r[prev_r] <= ST_SLEEPING;
                end
              end
              FN_KILL: begin
                if (!kill_ok) begin
                  halted_r <= 1'b1;
                  status_r <= STAT_HALT;
                end else begin
                  status_r     <= STAT_DONE;
                  ts_r[prev_r] <= ST_FREE;
                  if (ts_r[0] != ST_RUNNING) begin
                    ts_r[0] <= ST_READY;
                  end
                end
              end
              FN_READY: begin
                if (!ready_ok) begin
                  status_r <= STAT_IGNORED;
                end else begin
                  status_r       <= STAT_DONE;
                  ts_r[idx_slot] <= ST_READY;
                  ctx_r[idx_slot] <= 1'b1;
                end
              end
              default: status_r <= STAT_IGNORED;
            endcase
          end
        end
        OP_PREP: begin
          found_r <= 1'b0;
          rem_r   <= CntW'(prev_r) + CntW'(1);
          if (rd_st == ST_RUNNING) begin
            ts_r[prev_r] <= ST_READY;
          end
        end
        OP_MOD: begin
          if (rem_r < n) begin
            scan_r <= rem_r[SlotW-1:0];
            cnt_r  <= '0;
          end else begin
            rem_r <= rem_r - n;
          end
        end
        OP_SCAN: begin
          if (rd_st == ST_READY) begin
            found_r <= 1'b1;
            pick_r  <= scan_r;
          end else begin
            scan_r <= scan_next;
            cnt_r  <= cnt_r + CntW'(1);
          end
        end
        OP_FIX: begin
          if (!commit) begin
            if (rd_st == ST_READY) begin
              ts_r[prev_r] <= ST_RUNNING;
            end
            if (func_r == FN_KILL) begin
              halted_r <= 1'b1;
              status_r <= STAT_HALT;
            end
          end else if (pk == prev_r) begin
            ts_r[prev_r] <= ST_RUNNING;
            if (func_r == FN_KILL) begin
              halted_r <= 1'b1;
              status_r <= STAT_HALT;
            end
          end else if (!ctx_r[pk]) begin
            halted_r <= 1'b1;
            status_r <= STAT_HALT;
          end else begin
            ts_r[pk]      <= ST_RUNNING;
            ctx_r[prev_r] <= 1'b1;
            running_r     <= pk;
          end
        end
        OP_WK_CMP: begin
          if ((rd_st == ST_SLEEPING) && (now_r >= wk_q_r)) begin
            ts_r[wk_idx_r] <= ST_READY;
          end
          wk_idx_r <= wk_idx_r + SlotW'(1);
        end
        OP_NONE, OP_WK_ADDR, OP_LOAD_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/round_robin_task_scheduler.sv
// Round-robin task scheduler: one event per input transfer, one result each.
// Non-scheduling events go straight to the result; a schedule takes up to MAX_SLOTS
// start-slot subtractions, 1 to n scan steps (n = task_count capped at MAX_SLOTS; none
// when n is zero) and a fix step; a wakeup check reads and compares each of n wakeup times.
// One event is in flight at a time; the next is accepted in the cycle after the result is
// loaded, and a held result delays that load. Reset leaves slot 0 running and no halt.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_scheduler #(
  parameter int MAX_SLOTS = rrts_pkg::MAX_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic [1:0]  in_task_index,
  input  wire logic [31:0] in_sleep_ms,
  input  wire logic [63:0] in_tick_now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_switched,
  output logic [1:0]       out_prev_task,
  output logic [1:0]       out_next_task,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_wdata
);
  import rrts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrts_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_func       (in_func),
    .in_task_index (in_task_index),
    .in_sleep_ms   (in_sleep_ms),
    .in_tick_now   (in_tick_now),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_switched  (out_switched),
    .out_prev_task (out_prev_task),
    .out_next_task (out_next_task),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire
